### src/sfcs_pkg.sv
// Shared types and constants for the SPI flash command sequencer.
// Holds command codes, input mode codes, frame job descriptors and beat layout.
// No dependencies.
package sfcs_pkg;

  // Flash geometry
  localparam int unsigned PAGE_BYTES = 256;
  localparam int unsigned PAGE_BITS  = $clog2(PAGE_BYTES);

  // Job queue between front and back
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  // Flash command bytes
  localparam logic [7:0] CMD_ID     = 8'h9F;
  localparam logic [7:0] CMD_STATUS = 8'h05;
  localparam logic [7:0] CMD_WREN   = 8'h06;
  localparam logic [7:0] CMD_ERASE  = 8'h20;
  localparam logic [7:0] CMD_PROG   = 8'h02;
  localparam logic [7:0] CMD_READ   = 8'h03;
  localparam logic [7:0] DUMMY      = 8'hFF;

  // Input item modes
  localparam logic [2:0] MODE_START_WR = 3'd0;
  localparam logic [2:0] MODE_DATA     = 3'd1;
  localparam logic [2:0] MODE_START_RD = 3'd2;
  localparam logic [2:0] MODE_REPLY    = 3'd3;
  localparam logic [2:0] MODE_TICK     = 3'd4;

  // Request status codes
  localparam logic [1:0] ST_BUSY_RUN = 2'd0;
  localparam logic [1:0] ST_DONE     = 2'd1;
  localparam logic [1:0] ST_NORESP   = 2'd2;
  localparam logic [1:0] ST_TIMEOUT  = 2'd3;

  // Configuration register indexes
  localparam logic REG_POLL_LIMIT = 1'b0;
  localparam logic REG_EXP_MAKER  = 1'b1;

  // Reset values of the configuration registers
  localparam logic [7:0] POLL_LIMIT_RST = 8'd50;
  localparam logic [7:0] EXP_MAKER_RST  = 8'hEF;

  // Kind of byte sequence the back end expands a job into
  typedef enum logic [2:0] {
    K_ID,     // ID command and dummy
    K_POLL,   // status command and dummy
    K_BARE,   // one beat with no tx byte (status and/or read data)
    K_READ,   // read command, address, optional first dummy
    K_ERASE,  // write enable, sector erase, optional status poll
    K_PROG,   // write enable, page program, address
    K_RDATA,  // read dummy carrying the previous reply
    K_DATA    // program data byte, optional status poll
  } job_kind_e;

  // One job handed from front to back
  typedef struct packed {
    job_kind_e   kind;
    logic [23:0] addr;
    logic [7:0]  data;    // data byte or reply byte
    logic        stop;    // sequence ends early (request finished)
    logic        rel;     // release select after final dummy / poll tail
    logic        rdv;     // bare beat carries read data
    logic [1:0]  status;  // status on the final beat
  } job_t;

  // One output beat, tx_byte in the lowest bits
  typedef struct packed {
    logic [1:0] status;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       select_release;
    logic       tx_valid;
    logic [7:0] tx_byte;
  } beat_t;

endpackage

### src/sfcs_front.sv
// Front end: accepts items, runs the request phase machine, issues frame jobs.
// Holds the configuration registers. Depends on sfcs_pkg.
module sfcs_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_addr_i,
  input  logic [7:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic [2:0]        mode_i,
  input  logic [23:0]       address_i,
  input  logic [15:0]       byte_count_i,
  input  logic [7:0]        data_byte_i,
  input  logic [7:0]        reply_byte_i,
  input  logic              full_i,
  output logic              in_ready_o,
  output logic              push_o,
  output sfcs_pkg::job_t    job_o
);
  import sfcs_pkg::*;

  typedef enum logic [7:0] {
    PH_IDLE        = 8'b0000_0001,
    PH_ID          = 8'b0000_0010,
    PH_FIRST_WAIT  = 8'b0000_0100,
    PH_FIRST_DELAY = 8'b0000_1000,
    PH_PROG_WAIT   = 8'b0001_0000,
    PH_PROG_DELAY  = 8'b0010_0000,
    PH_DATA        = 8'b0100_0000,
    PH_READ        = 8'b1000_0000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [23:0] addr_q, addr_d;
  logic [15:0] left_q, left_d;
  logic [7:0]  pcnt_q, pcnt_d;
  logic        isrd_q, isrd_d;
  logic [7:0]  poll_limit_q, exp_maker_q;

  logic        in_acc;
  logic [15:0] left_dec;
  logic [23:0] addr_inc;
  logic [7:0]  pcnt_inc;
  logic        busy;

  assign in_ready_o = ~full_i;
  assign in_acc     = in_valid_i & ~full_i;
  assign left_dec   = left_q - 16'd1;
  assign addr_inc   = addr_q + 24'd1;
  assign pcnt_inc   = pcnt_q + 8'd1;
  assign busy       = reply_byte_i[0];

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_limit_q <= POLL_LIMIT_RST;
      exp_maker_q  <= EXP_MAKER_RST;
    end else if (cfg_we_i) begin
      if (cfg_addr_i == REG_POLL_LIMIT) poll_limit_q <= cfg_wdata_i;
      if (cfg_addr_i == REG_EXP_MAKER)  exp_maker_q  <= cfg_wdata_i;
    end
  end

  // Phase machine and job generation
  always_comb begin
    phase_d = phase_q;
    addr_d  = addr_q;
    left_d  = left_q;
    pcnt_d  = pcnt_q;
    isrd_d  = isrd_q;
    push_o  = 1'b0;
    job_o        = '0;
    job_o.kind   = K_BARE;
    job_o.addr   = addr_q;
    job_o.status = ST_BUSY_RUN;

    if (in_acc) begin
      if ((mode_i == MODE_START_WR || mode_i == MODE_START_RD) && phase_q == PH_IDLE) begin
        addr_d     = address_i;
        left_d     = byte_count_i;
        isrd_d     = (mode_i == MODE_START_RD);
        pcnt_d     = 8'd0;
        push_o     = 1'b1;
        job_o.kind = K_ID;
        phase_d    = PH_ID;
      end else if (mode_i == MODE_REPLY) begin
        unique case (phase_q)
          PH_ID: begin
            push_o = 1'b1;
            if (reply_byte_i != exp_maker_q) begin
              job_o.kind   = K_BARE;
              job_o.status = ST_NORESP;
              phase_d      = PH_IDLE;
            end else begin
              job_o.kind = K_POLL;
              pcnt_d     = 8'd0;
              phase_d    = PH_FIRST_WAIT;
            end
          end
          PH_FIRST_WAIT, PH_PROG_WAIT: begin
            if (!busy) begin
              push_o = 1'b1;
              if (phase_q == PH_PROG_WAIT) begin
                job_o.kind = K_PROG;
                phase_d    = PH_DATA;
              end else if (isrd_q) begin
                job_o.kind   = K_READ;
                job_o.stop   = (left_q == 16'd0);
                job_o.rel    = (left_q == 16'd1);
                job_o.status = (left_q == 16'd0) ? ST_DONE : ST_BUSY_RUN;
                phase_d      = (left_q == 16'd0) ? PH_IDLE : PH_READ;
              end else begin
                job_o.kind   = K_ERASE;
                job_o.stop   = (left_q == 16'd0);
                job_o.status = (left_q == 16'd0) ? ST_DONE : ST_BUSY_RUN;
                pcnt_d       = 8'd0;
                phase_d      = (left_q == 16'd0) ? PH_IDLE : PH_PROG_WAIT;
              end
            end else begin
              pcnt_d = pcnt_inc;
              if (pcnt_inc >= poll_limit_q) begin
                push_o       = 1'b1;
                job_o.kind   = K_BARE;
                job_o.status = ST_TIMEOUT;
                phase_d      = PH_IDLE;
              end else begin
                phase_d = (phase_q == PH_FIRST_WAIT) ? PH_FIRST_DELAY : PH_PROG_DELAY;
              end
            end
          end
          PH_READ: begin
            left_d     = left_dec;
            addr_d     = addr_inc;
            push_o     = 1'b1;
            job_o.data = reply_byte_i;
            if (left_dec == 16'd0) begin
              job_o.kind   = K_BARE;
              job_o.rdv    = 1'b1;
              job_o.status = ST_DONE;
              phase_d      = PH_IDLE;
            end else begin
              job_o.kind = K_RDATA;
              job_o.rel  = (left_dec == 16'd1);
            end
          end
          default: begin
          end
        endcase
      end else if (mode_i == MODE_TICK) begin
        if (phase_q == PH_FIRST_DELAY) begin
          push_o     = 1'b1;
          job_o.kind = K_POLL;
          phase_d    = PH_FIRST_WAIT;
        end else if (phase_q == PH_PROG_DELAY) begin
          push_o     = 1'b1;
          job_o.kind = K_POLL;
          phase_d    = PH_PROG_WAIT;
        end
      end else if (mode_i == MODE_DATA && phase_q == PH_DATA) begin
        left_d     = left_dec;
        addr_d     = addr_inc;
        push_o     = 1'b1;
        job_o.kind = K_DATA;
        job_o.data = data_byte_i;
        if (left_dec == 16'd0) begin
          job_o.stop   = 1'b1;
          job_o.status = ST_DONE;
          phase_d      = PH_IDLE;
        end else if (addr_inc[PAGE_BITS-1:0] == '0) begin
          // page boundary: close the frame and wait for busy again
          job_o.rel = 1'b1;
          pcnt_d    = 8'd0;
          phase_d   = PH_PROG_WAIT;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      addr_q  <= '0;
      left_q  <= '0;
      pcnt_q  <= '0;
      isrd_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      addr_q  <= addr_d;
      left_q  <= left_d;
      pcnt_q  <= pcnt_d;
      isrd_q  <= isrd_d;
    end
  end

endmodule

### src/sfcs_fifo.sv
// Short job queue between the front and back ends.
// Depends on sfcs_pkg for the job type and depth.
module sfcs_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sfcs_pkg::job_t job_i,
  input  logic           pop_i,
  output sfcs_pkg::job_t job_o,
  output logic           full_o,
  output logic           empty_o
);
  import sfcs_pkg::*;

  job_t             mem_q [FIFO_DEPTH];
  logic [FIFO_AW:0] wptr_q, wptr_d;
  logic [FIFO_AW:0] rptr_q, rptr_d;

  assign empty_o = (wptr_q == rptr_q);
  assign full_o  = (wptr_q[FIFO_AW-1:0] == rptr_q[FIFO_AW-1:0]) &&
                   (wptr_q[FIFO_AW] != rptr_q[FIFO_AW]);
  assign job_o   = mem_q[rptr_q[FIFO_AW-1:0]];

  assign wptr_d = wptr_q + {{FIFO_AW{1'b0}}, (push_i & ~full_o)};
  assign rptr_d = rptr_q + {{FIFO_AW{1'b0}}, (pop_i & ~empty_o)};

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wptr_q[FIFO_AW-1:0]] <= job_i;
  end

  // Pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
    end
  end

endmodule

### src/sfcs_back.sv
// Back end: expands each job into output beats, one per cycle while the output
// is not stalled, into a registered output stage. Depends on sfcs_pkg.
module sfcs_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sfcs_pkg::job_t job_i,
  input  logic           empty_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output sfcs_pkg::beat_t beat_o,
  output logic           last_o
);
  import sfcs_pkg::*;

  job_t       job_q, job_d;
  logic       jvalid_q, jvalid_d;
  logic [2:0] idx_q, idx_d;
  beat_t      out_q, out_d;
  logic       ovalid_q, ovalid_d;
  logic       olast_q, olast_d;

  beat_t      beat;
  logic       blast;
  logic       out_free, adv, load;

  // Beat generator for the current job and position
  always_comb begin
    beat  = '0;
    blast = 1'b0;
    beat.tx_valid = 1'b1;
    unique case (job_q.kind)
      K_ID, K_POLL: begin
        if (idx_q == 3'd0) begin
          beat.tx_byte = (job_q.kind == K_ID) ? CMD_ID : CMD_STATUS;
        end else begin
          beat.tx_byte        = DUMMY;
          beat.select_release = 1'b1;
          blast               = 1'b1;
        end
      end
      K_BARE: begin
        beat.tx_valid   = 1'b0;
        beat.read_byte  = job_q.rdv ? job_q.data : 8'd0;
        beat.read_valid = job_q.rdv;
        blast           = 1'b1;
      end
      K_READ: begin
        unique case (idx_q)
          3'd0: beat.tx_byte = CMD_READ;
          3'd1: beat.tx_byte = job_q.addr[23:16];
          3'd2: beat.tx_byte = job_q.addr[15:8];
          3'd3: begin
            beat.tx_byte        = job_q.addr[7:0];
            beat.select_release = job_q.stop;
            blast               = job_q.stop;
          end
          default: begin
            beat.tx_byte        = DUMMY;
            beat.select_release = job_q.rel;
            blast               = 1'b1;
          end
        endcase
      end
      K_ERASE: begin
        unique case (idx_q)
          3'd0: begin
            beat.tx_byte        = CMD_WREN;
            beat.select_release = 1'b1;
          end
          3'd1: beat.tx_byte = CMD_ERASE;
          3'd2: beat.tx_byte = job_q.addr[23:16];
          3'd3: beat.tx_byte = job_q.addr[15:8];
          3'd4: begin
            beat.tx_byte        = job_q.addr[7:0];
            beat.select_release = 1'b1;
            blast               = job_q.stop;
          end
          3'd5: beat.tx_byte = CMD_STATUS;
          default: begin
            beat.tx_byte        = DUMMY;
            beat.select_release = 1'b1;
            blast               = 1'b1;
          end
        endcase
      end
      K_PROG: begin
        unique case (idx_q)
          3'd0: begin
            beat.tx_byte        = CMD_WREN;
            beat.select_release = 1'b1;
          end
          3'd1: beat.tx_byte = CMD_PROG;
          3'd2: beat.tx_byte = job_q.addr[23:16];
          3'd3: beat.tx_byte = job_q.addr[15:8];
          default: begin
            beat.tx_byte = job_q.addr[7:0];
            blast        = 1'b1;
          end
        endcase
      end
      K_RDATA: begin
        beat.tx_byte        = DUMMY;
        beat.select_release = job_q.rel;
        beat.read_byte      = job_q.data;
        beat.read_valid     = 1'b1;
        blast               = 1'b1;
      end
      K_DATA: begin
        // data byte, then a status poll when the page frame closed
        unique case (idx_q)
          3'd0: begin
            beat.tx_byte        = job_q.data;
            beat.select_release = job_q.stop | job_q.rel;
            blast               = ~job_q.rel;
          end
          3'd1: beat.tx_byte = CMD_STATUS;
          default: begin
            beat.tx_byte        = DUMMY;
            beat.select_release = 1'b1;
            blast               = 1'b1;
          end
        endcase
      end
      default: begin
        blast = 1'b1;
      end
    endcase
    if (blast) beat.status = job_q.status;
  end

  // Job sequencing and output register
  assign out_free = ~ovalid_q | out_ready_i;
  assign adv      = jvalid_q & out_free;
  assign load     = (~jvalid_q | (adv & blast)) & ~empty_i;
  assign pop_o    = load;

  always_comb begin
    job_d    = job_q;
    jvalid_d = jvalid_q;
    idx_d    = idx_q;
    out_d    = out_q;
    olast_d  = olast_q;
    ovalid_d = ovalid_q;
    if (load) begin
      job_d    = job_i;
      jvalid_d = 1'b1;
      idx_d    = 3'd0;
    end else if (adv) begin
      jvalid_d = ~blast;
      idx_d    = idx_q + 3'd1;
    end
    if (out_free) begin
      ovalid_d = adv;
      if (adv) begin
        out_d   = beat;
        olast_d = blast;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jvalid_q <= 1'b0;
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      jvalid_q <= jvalid_d;
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q   <= job_d;
    out_q   <= out_d;
    olast_q <= olast_d;
  end

  assign out_valid_o = ovalid_q;
  assign beat_o      = out_q;
  assign last_o      = olast_q;

endmodule

### src/spi_flash_command_sequencer.sv
// SPI flash command sequencer: one input item per cycle while the job queue is
// not full; the back end sends one output beat per cycle while the output is ready.
// An accepted item reaches the output through the job queue write, the job
// load in the back end and the output register.
// Reset (async, active low) returns the phase machine to idle, empties the
// queue and loads poll_limit 50 and expected_maker 0xEF.
// Depends on sfcs_pkg, sfcs_front, sfcs_fifo, sfcs_back.
module spi_flash_command_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [7:0]  cfg_wdata_i,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // address[23:0], byte_count[39:24],
                                     // data_byte[47:40], reply_byte[55:48]
  input  logic [2:0]  s_axis_tuser,  // mode[2:0]
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // tx_byte[7:0], tx_valid[8],
                                     // select_release[9], read_byte[17:10],
                                     // read_valid[18], status[20:19], zero[23:21]
  output logic        m_axis_tlast
);
  import sfcs_pkg::*;

  job_t  job_push, job_head;
  logic  push, pop, full, empty;
  beat_t beat;

  sfcs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (s_axis_tvalid),
    .mode_i       (s_axis_tuser),
    .address_i    (s_axis_tdata[23:0]),
    .byte_count_i (s_axis_tdata[39:24]),
    .data_byte_i  (s_axis_tdata[47:40]),
    .reply_byte_i (s_axis_tdata[55:48]),
    .full_i       (full),
    .in_ready_o   (s_axis_tready),
    .push_o       (push),
    .job_o        (job_push)
  );

  sfcs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_push),
    .pop_i   (pop),
    .job_o   (job_head),
    .full_o  (full),
    .empty_o (empty)
  );

  sfcs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .beat_o      (beat),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, beat};

endmodule
